@@ rtl/core/b2d_pkg.sv @@
// Shared constants, types and helpers for the binary to decimal ASCII converter.
package b2d_pkg;

	parameter int VALUE_BITS_DEF = 31;

	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 6;

	localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
	localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ  = 4'd3;

	typedef enum logic [1:0] {
		CONV_IDLE,
		CONV_SHIFT,
		CONV_DONE
	} conv_state_t;

	typedef enum logic [1:0] {
		EMIT_IDLE,
		EMIT_SKIP,
		EMIT_SEND
	} emit_state_t;

	// Decimal digits needed for an unsigned word of the given width: floor(bits*log10(2))+1.
	function automatic int bcd_digits(input int bits);
		return (bits * 30103) / 100000 + 1;
	endfunction

endpackage

@@ rtl/core/b2d_dabble.sv @@
// Bit-serial shift-and-add-3 converter from binary to packed BCD.
module b2d_dabble #(
	parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEF,
	localparam int DIGITS   = b2d_pkg::bcd_digits(VALUE_BITS),
	localparam int BCD_BITS = DIGITS * b2d_pkg::DIGIT_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  value_valid,
	output logic                  value_stall,
	output logic [BCD_BITS-1:0]   bcd,
	output logic                  bcd_valid,
	input  logic                  bcd_take
);
	import b2d_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	conv_state_t           state_q, state_d;
	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_BITS-1:0]   bcd_q, bcd_adj;
	logic [CNT_W-1:0]      cnt_q;
	logic                  accept;

	assign accept = value_valid && !value_stall;

	// Add 3 to every digit of 5 or more ahead of the shift.
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_FIVE) begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_ADJ;
			end else begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CONV_IDLE: begin
				if (value_valid) state_d = CONV_SHIFT;
			end
			CONV_SHIFT: begin
				if (cnt_q == CNT_W'(1)) state_d = CONV_DONE;
			end
			CONV_DONE: begin
				if (bcd_take) state_d = CONV_IDLE;
			end
			default: state_d = CONV_IDLE;
		endcase
	end

	always_comb begin
		value_stall = (state_q != CONV_IDLE);
		bcd_valid   = (state_q == CONV_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CONV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= value;
			bcd_q <= '0;
			cnt_q <= CNT_W'(VALUE_BITS);
		end else if (state_q == CONV_SHIFT) begin
			bcd_q <= {bcd_adj[BCD_BITS-2:0], bin_q[VALUE_BITS-1]};
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign bcd = bcd_q;

endmodule

@@ rtl/core/b2d_emit.sv @@
// Digit shifter: drops leading zeros and sends ASCII digits most significant first.
module b2d_emit #(
	parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEF,
	localparam int DIGITS   = b2d_pkg::bcd_digits(VALUE_BITS),
	localparam int BCD_BITS = DIGITS * b2d_pkg::DIGIT_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [BCD_BITS-1:0]         bcd,
	input  logic                        bcd_valid,
	output logic                        bcd_take,
	output logic [b2d_pkg::CHAR_W-1:0]  digit_char,
	output logic                        last_digit,
	output logic                        digit_valid,
	input  logic                        digit_stall
);
	import b2d_pkg::*;

	localparam int REM_W = $clog2(DIGITS + 1);

	emit_state_t         state_q, state_d;
	logic [BCD_BITS-1:0] sh_q;
	logic [REM_W-1:0]    rem_q;
	logic [DIGIT_W-1:0]  top;
	logic                one_left;
	logic                slot_free;
	logic                load, skip, send;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;
	logic                valid_q;

	assign top       = sh_q[BCD_BITS-1 -: DIGIT_W];
	assign one_left  = (rem_q == REM_W'(1));
	assign slot_free = !valid_q || !digit_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EMIT_IDLE: begin
				if (bcd_valid) state_d = EMIT_SKIP;
			end
			EMIT_SKIP: begin
				if (top != '0 || one_left) state_d = EMIT_SEND;
			end
			EMIT_SEND: begin
				if (slot_free && one_left) state_d = EMIT_IDLE;
			end
			default: state_d = EMIT_IDLE;
		endcase
	end

	always_comb begin
		load = (state_q == EMIT_IDLE) && bcd_valid;
		skip = (state_q == EMIT_SKIP) && top == '0 && !one_left;
		send = (state_q == EMIT_SEND) && slot_free;
	end

	assign bcd_take = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EMIT_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (send) begin
				valid_q <= 1'b1;
			end else if (!digit_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q  <= bcd;
			rem_q <= REM_W'(DIGITS);
		end else if (skip || send) begin
			sh_q  <= {sh_q[BCD_BITS-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
			rem_q <= rem_q - REM_W'(1);
		end
		if (send) begin
			char_q <= ASCII_ZERO + CHAR_W'(top);
			last_q <= one_left;
		end
	end

	assign digit_char  = char_q;
	assign last_digit  = last_q;
	assign digit_valid = valid_q;

endmodule

@@ rtl/core/binary_to_decimal_ascii.sv @@
// Top level of the binary to decimal ASCII converter.
//
// Input channel: value with value_valid / value_stall. One unsigned integer
// per transfer. Output channel: digit_char and last_digit with digit_valid /
// digit_stall, one ASCII digit per transfer, most significant first, no
// leading zeros; last_digit marks the final digit. Zero gives a single '0'.
// The converter takes one input bit per cycle in a shift-and-add-3 register,
// so value_stall stays high while the bits of a value are shifted in and
// then until the digit shifter has taken the BCD word. The shifter drops one
// leading zero per cycle, then sends one digit per cycle while digit_stall
// is low. A new value is accepted once the shifter has taken the BCD word of
// the previous one, so conversion of the next value overlaps the sending of
// the current one. A stalled receiver holds the output register and, behind
// it, the shifter and then the converter; nothing is lost. Reset (arst_n low)
// clears both state machines and the output valid flag and drops any item in
// flight.
module binary_to_decimal_ascii #(
	parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [VALUE_BITS-1:0]      value,
	input  logic                       value_valid,
	output logic                       value_stall,
	output logic [b2d_pkg::CHAR_W-1:0] digit_char,
	output logic                       last_digit,
	output logic                       digit_valid,
	input  logic                       digit_stall
);
	import b2d_pkg::*;

	localparam int BCD_BITS = bcd_digits(VALUE_BITS) * DIGIT_W;

	logic [BCD_BITS-1:0] bcd;
	logic                bcd_valid;
	logic                bcd_take;

	b2d_dabble #(
		.VALUE_BITS(VALUE_BITS)
	) u_dabble (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.bcd         (bcd),
		.bcd_valid   (bcd_valid),
		.bcd_take    (bcd_take)
	);

	b2d_emit #(
		.VALUE_BITS(VALUE_BITS)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.bcd         (bcd),
		.bcd_valid   (bcd_valid),
		.bcd_take    (bcd_take),
		.digit_char  (digit_char),
		.last_digit  (last_digit),
		.digit_valid (digit_valid),
		.digit_stall (digit_stall)
	);

endmodule
